>>> hdl/tsw_pkg.sv
package tsw_pkg;

  localparam int QueueDepthDefault = 64;
  localparam int MaxSegs = 61;
  localparam logic [31:0] TimeoutDefault = 32'd1000;
  localparam logic [10:0] MaxPayloadDefault = 11'd1452;

  // event codes
  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_EACK = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_ISN = 2'd0;
  localparam logic [1:0] REG_RTO = 2'd1;
  localparam logic [1:0] REG_MSS = 2'd2;

  // word handed from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] ack_number;
    logic [15:0] rcv_window;
    logic [15:0] tick_ms;
    logic [15:0] stream_bytes;
    logic        stream_ended;
  } evt_t;

  // one result word
  typedef struct packed {
    logic        segment_valid;
    logic [31:0] seq_number;
    logic [10:0] payload_len;
    logic        syn_flag;
    logic        fin_flag;
    logic        ack_flag;
    logic        is_retransmit;
    logic [31:0] in_flight;
    logic [7:0]  retry_count;
    logic        last_item;
  } res_t;

endpackage

>>> hdl/tsw_front.sv
module tsw_front #(
  parameter int Depth = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  tsw_pkg::evt_t   in_word,
  output logic            q_valid,
  input  logic            q_take,
  output tsw_pkg::evt_t   q_word
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  tsw_pkg::evt_t mem [Depth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   count;
  logic          push;
  logic          pop;

  assign in_stall = (count == (Aw+1)'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_take;
  assign q_word   = mem[rd_ptr];

  // event queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_word;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

>>> hdl/tsw_back.sv
module tsw_back #(
  parameter int QueueDepth = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           q_valid,
  output logic           q_take,
  input  tsw_pkg::evt_t  q_word,
  output logic           out_valid,
  input  logic           out_stall,
  output tsw_pkg::res_t  out_word
);

  localparam int Qa = $clog2(QueueDepth);

  typedef enum logic [3:0] {
    S_IDLE, S_ACK_CHK, S_SCAN_RD, S_SCAN, S_POP_RD, S_POP, S_ACK_END,
    S_FILL, S_FIN, S_TICK, S_RETX_RD, S_RETX, S_EMIT, S_STATUS
  } state_t;

  state_t        state;
  state_t        ret_state;
  tsw_pkg::evt_t ev;

  logic [31:0] isn;
  logic [15:0] init_to;
  logic [10:0] mss;

  logic        syn_sent, fin_sent, timer_running;
  logic [63:0] next_abs_seq, last_abs_ack, max_abs_ack;
  logic [31:0] flight_bytes;
  logic [16:0] send_window;
  logic [15:0] peer_window;
  logic [31:0] elapsed_ms, current_timeout;
  logic [7:0]  retries;
  logic [Qa-1:0] head;
  logic [Qa:0]   pcount;
  logic [15:0]   rem;
  logic [5:0]    nsegs;
  logic [63:0]   abs_ack;

  // outstanding segment memory
  logic [63:0]   q_end [QueueDepth];
  logic [10:0]   q_len [QueueDepth];
  logic [1:0]    q_flg [QueueDepth];
  logic          wr_en;
  logic [Qa-1:0] wr_addr;
  logic [63:0]   wr_end;
  logic [10:0]   wr_len;
  logic [1:0]    wr_flg;
  logic [Qa-1:0] rd_addr;
  logic [63:0]   rd_end;
  logic [10:0]   rd_len;
  logic [1:0]    rd_flg;
  logic [Qa:0]   scan_i;
  logic [Qa:0]   pop_n;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_end[wr_addr] <= wr_end;
      q_len[wr_addr] <= wr_len;
      q_flg[wr_addr] <= wr_flg;
    end
    rd_end <= q_end[rd_addr];
    rd_len <= q_len[rd_addr];
    rd_flg <= q_flg[rd_addr];
  end

  // ack unwrapping around the last accepted ack
  logic [63:0] uw_t;
  logic [63:0] uw_off;
  always_comb begin
    uw_off = {32'd0, ev.ack_number - isn};
    uw_t   = uw_off + {last_abs_ack[63:32], 32'd0};
    if (uw_t > last_abs_ack) begin
      if (uw_t[63:32] != '0 && (uw_t - last_abs_ack) > 64'h8000_0000) begin
        uw_t = uw_t - 64'h1_0000_0000;
      end
    end else if ((last_abs_ack - uw_t) >= 64'h8000_0000 &&
                 uw_t[63:32] != 32'hFFFF_FFFF) begin
      uw_t = uw_t + 64'h1_0000_0000;
    end
  end

  // fill step decisions
  logic        can_send;
  logic [16:0] take_w;
  logic [15:0] take;
  logic [15:0] rem_after;
  logic [16:0] win_after;
  logic        fin_here;
  logic [10:0] mp;
  always_comb begin
    mp        = (mss == '0) ? 11'd1 : mss;
    can_send  = (pcount < (Qa+1)'(QueueDepth)) && (nsegs < 6'(tsw_pkg::MaxSegs));
    take_w    = (send_window > {6'd0, mp}) ? {6'd0, mp} : send_window;
    take      = (take_w > {1'b0, rem}) ? rem : take_w[15:0];
    rem_after = rem - take;
    win_after = send_window - {1'b0, take};
    fin_here  = ev.stream_ended && rem_after == '0 && win_after != '0;
  end

  // segment launch values
  logic [10:0] seg_len;
  logic        seg_syn, seg_fin;
  logic [31:0] seg_l;
  assign seg_l = {21'd0, seg_len} + {31'd0, seg_syn} + {31'd0, seg_fin};

  logic [63:0] ack_gap;
  assign ack_gap = next_abs_seq - abs_ack;

  logic [32:0] to_dbl;
  assign to_dbl = {current_timeout, 1'b0};

  logic [32:0] el_sum;
  logic [31:0] el_sat;
  assign el_sum = {1'b0, elapsed_ms} + {17'd0, ev.tick_ms};
  assign el_sat = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

  assign q_take = (state == S_IDLE);

  always_comb begin
    wr_addr = head + pcount[Qa-1:0];
    wr_end  = next_abs_seq + {32'd0, seg_l};
    wr_len  = seg_len;
    wr_flg  = {seg_syn, seg_fin};
    wr_en   = (state == S_EMIT) && !out_valid && (ev.op != tsw_pkg::OP_EACK);
    // during the scan the next entry is read while the current one is compared
    unique case (state)
      S_SCAN_RD: rd_addr = head + scan_i[Qa-1:0];
      S_SCAN:    rd_addr = head + scan_i[Qa-1:0] + 1'b1;
      default:   rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ret_state <= S_STATUS;
      isn <= '0; init_to <= 16'(tsw_pkg::TimeoutDefault);
      mss <= tsw_pkg::MaxPayloadDefault;
      syn_sent <= 1'b0; fin_sent <= 1'b0; timer_running <= 1'b0;
      next_abs_seq <= '0; last_abs_ack <= '0; max_abs_ack <= '0;
      flight_bytes <= '0; send_window <= '0; peer_window <= '0;
      elapsed_ms <= '0; current_timeout <= '0; retries <= '0;
      head <= '0; pcount <= '0; out_valid <= 1'b0;
      nsegs <= '0; rem <= '0; scan_i <= '0; pop_n <= '0;
      seg_len <= '0; seg_syn <= 1'b0; seg_fin <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          tsw_pkg::REG_ISN: isn <= cfg_data;
          tsw_pkg::REG_RTO: init_to <= cfg_data[15:0];
          tsw_pkg::REG_MSS: mss <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            ev <= q_word; rem <= q_word.stream_bytes; nsegs <= '0;
            ret_state <= (q_word.op == tsw_pkg::OP_EACK) ? S_STATUS : S_FILL;
            unique case (q_word.op)
              tsw_pkg::OP_FILL: state <= S_FILL;
              tsw_pkg::OP_ACK:  state <= S_ACK_CHK;
              tsw_pkg::OP_TICK: state <= S_TICK;
              default:          state <= S_EMIT;
            endcase
            if (q_word.op == tsw_pkg::OP_EACK) begin
              seg_len <= '0; seg_syn <= 1'b0; seg_fin <= 1'b0;
            end
          end
        end
        S_ACK_CHK: begin
          abs_ack <= uw_t;
          scan_i <= '0; pop_n <= '0;
          if (uw_t > next_abs_seq) state <= S_STATUS;
          else state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (ack_gap > {48'd0, ev.rcv_window}) begin
            send_window <= '0; state <= S_STATUS;
          end else begin
            last_abs_ack <= abs_ack; peer_window <= ev.rcv_window;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one entry a cycle: read issued, then compare
          if (scan_i >= pcount) begin
            state <= S_POP_RD;
          end else begin
            state <= S_SCAN;
            if (rd_end == abs_ack) begin
              pop_n <= scan_i + 1'b1; scan_i <= pcount;
            end else begin
              scan_i <= scan_i + 1'b1;
            end
          end
        end
        S_POP_RD: state <= (pop_n == '0) ? S_ACK_END : S_POP;
        S_POP: begin
          flight_bytes <= flight_bytes - ({21'd0, rd_len} +
                          {31'd0, rd_flg[1]} + {31'd0, rd_flg[0]});
          head <= head + 1'b1; pcount <= pcount - 1'b1;
          pop_n <= pop_n - 1'b1;
          state <= S_POP_RD;
        end
        S_ACK_END: begin
          send_window <= (ev.rcv_window == '0) ? 17'd1 :
            17'(abs_ack + {48'd0, ev.rcv_window} - next_abs_seq);
          if (abs_ack > max_abs_ack) begin
            max_abs_ack <= abs_ack; current_timeout <= {16'd0, init_to};
            retries <= '0;
            if (pcount != '0) elapsed_ms <= '0;
          end
          if (pcount == '0) timer_running <= 1'b0;
          state <= S_FILL;
        end
        S_FILL: begin
          if (!syn_sent) begin
            if (can_send) begin
              syn_sent <= 1'b1; seg_len <= '0; seg_syn <= 1'b1; seg_fin <= 1'b0;
              ret_state <= S_STATUS; state <= S_EMIT;
            end else state <= S_STATUS;
          end else if (!fin_sent && rem != '0 && send_window != '0 && can_send) begin
            rem <= rem_after; seg_len <= take[10:0]; seg_syn <= 1'b0;
            seg_fin <= fin_here;
            send_window <= fin_here ? win_after - 1'b1 : win_after;
            if (fin_here) fin_sent <= 1'b1;
            ret_state <= S_FILL; state <= S_EMIT;
          end else state <= S_FIN;
        end
        S_FIN: begin
          if (!fin_sent && ev.stream_ended && rem == '0 && send_window != '0 &&
              can_send) begin
            send_window <= send_window - 1'b1; fin_sent <= 1'b1;
            seg_len <= '0; seg_syn <= 1'b0; seg_fin <= 1'b1;
            ret_state <= S_STATUS; state <= S_EMIT;
          end else state <= S_STATUS;
        end
        S_TICK: begin
          if (timer_running && pcount != '0 && el_sat >= current_timeout) begin
            state <= S_RETX_RD;
          end else begin
            state <= S_STATUS;
          end
          if (timer_running) begin
            if (pcount != '0) begin
              if (el_sat >= current_timeout) begin
                elapsed_ms <= '0;
                if (peer_window != '0) begin
                  if (retries != 8'hFF) retries <= retries + 1'b1;
                  current_timeout <= to_dbl[32] ? 32'hFFFF_FFFF : to_dbl[31:0];
                end
              end else elapsed_ms <= el_sat;
            end else begin
              // empty queue: 0 reaches timeout only when it is zero
              elapsed_ms <= '0;
              current_timeout <= {16'd0, init_to};
              if (init_to == '0 && peer_window != '0) begin
                if (retries != 8'hFF) retries <= retries + 1'b1;
              end
            end
          end
        end
        S_RETX_RD: state <= S_RETX;
        S_RETX: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_word <= '{segment_valid: 1'b1,
              seq_number: 32'(rd_end - {53'd0, rd_len} - {63'd0, rd_flg[1]} -
                              {63'd0, rd_flg[0]}) + isn,
              payload_len: rd_len, syn_flag: rd_flg[1], fin_flag: rd_flg[0],
              ack_flag: 1'b0, is_retransmit: 1'b1, in_flight: flight_bytes,
              retry_count: retries, last_item: 1'b0};
            state <= S_STATUS;
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (ev.op == tsw_pkg::OP_EACK) begin
              out_word <= '{segment_valid: 1'b1, seq_number: next_abs_seq[31:0] + isn,
                payload_len: '0, syn_flag: 1'b0, fin_flag: 1'b0, ack_flag: 1'b1,
                is_retransmit: 1'b0, in_flight: flight_bytes,
                retry_count: retries, last_item: 1'b0};
            end else begin
              flight_bytes <= flight_bytes + seg_l;
              next_abs_seq <= next_abs_seq + {32'd0, seg_l};
              pcount <= pcount + 1'b1; nsegs <= nsegs + 1'b1;
              if (!timer_running) begin
                elapsed_ms <= '0; current_timeout <= {16'd0, init_to};
                timer_running <= 1'b1;
              end
              out_word <= '{segment_valid: 1'b1, seq_number: next_abs_seq[31:0] + isn,
                payload_len: seg_len, syn_flag: seg_syn, fin_flag: seg_fin,
                ack_flag: 1'b0, is_retransmit: 1'b0,
                in_flight: flight_bytes + seg_l,
                retry_count: retries, last_item: 1'b0};
            end
            state <= ret_state;
          end
        end
        S_STATUS: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_word <= '{segment_valid: 1'b0, seq_number: next_abs_seq[31:0] + isn,
              payload_len: '0, syn_flag: 1'b0, fin_flag: 1'b0, ack_flag: 1'b0,
              is_retransmit: 1'b0, in_flight: flight_bytes,
              retry_count: retries, last_item: 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/tcp_sender_window_retransmit.sv
// TCP sender control engine. Events (fill, ack, tick, empty ack) enter a
// four-word queue and are worked one at a time; each ends with a status word
// (last_item high). An ack that is accepted first walks the outstanding-segment
// memory one entry a cycle until it finds the match, then retires the matched
// entries one by one (a read state, then a retire state) before filling. A tick
// may resend the oldest segment.
module tcp_sender_window_retransmit #(
  parameter int QUEUE_DEPTH = tsw_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] ack_number,
  input  logic [15:0] rcv_window,
  input  logic [15:0] tick_ms,
  input  logic [15:0] stream_bytes,
  input  logic        stream_ended,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        segment_valid,
  output logic [31:0] seq_number,
  output logic [10:0] payload_len,
  output logic        syn_flag,
  output logic        fin_flag,
  output logic        ack_flag,
  output logic        is_retransmit,
  output logic [31:0] in_flight,
  output logic [7:0]  retry_count,
  output logic        last_item
);

  tsw_pkg::evt_t in_word;
  tsw_pkg::evt_t q_word;
  tsw_pkg::res_t res;
  logic          q_valid;
  logic          q_take;

  assign in_word = '{op: tsw_pkg::op_t'(opcode), ack_number: ack_number,
                     rcv_window: rcv_window, tick_ms: tick_ms,
                     stream_bytes: stream_bytes, stream_ended: stream_ended};

  // front: event queue
  tsw_front #(.Depth(4)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .q_valid, .q_take, .q_word
  );

  // back: sender state machine
  tsw_back #(.QueueDepth(QUEUE_DEPTH)) u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_take, .q_word,
    .out_valid, .out_stall, .out_word(res)
  );

  assign segment_valid = res.segment_valid;
  assign seq_number    = res.seq_number;
  assign payload_len   = res.payload_len;
  assign syn_flag      = res.syn_flag;
  assign fin_flag      = res.fin_flag;
  assign ack_flag      = res.ack_flag;
  assign is_retransmit = res.is_retransmit;
  assign in_flight     = res.in_flight;
  assign retry_count   = res.retry_count;
  assign last_item     = res.last_item;

`ifndef NO_ASSERTIONS
  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res))
    else $error("output word changed under stall");
  // status words never flag a segment
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_item |-> !segment_valid && !syn_flag && !fin_flag)
    else $error("status word carries segment flags");
  // an ack-only descriptor carries no other flag
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_flag |-> !syn_flag && !fin_flag && !is_retransmit)
    else $error("ack-only word carries other flags");
`endif

endmodule

>>> bench/tb_top.sv
module tb_top;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [31:0] ack_number;
  logic [15:0] rcv_window;
  logic [15:0] tick_ms;
  logic [15:0] stream_bytes;
  logic        stream_ended;
  logic        out_valid;
  logic        out_stall;
  logic        segment_valid;
  logic [31:0] seq_number;
  logic [10:0] payload_len;
  logic        syn_flag;
  logic        fin_flag;
  logic        ack_flag;
  logic        is_retransmit;
  logic [31:0] in_flight;
  logic [7:0]  retry_count;
  logic        last_item;

  tcp_sender_window_retransmit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .ack_number(ack_number),
    .rcv_window(rcv_window), .tick_ms(tick_ms), .stream_bytes(stream_bytes),
    .stream_ended(stream_ended), .out_valid(out_valid), .out_stall(out_stall),
    .segment_valid(segment_valid), .seq_number(seq_number), .payload_len(payload_len),
    .syn_flag(syn_flag), .fin_flag(fin_flag), .ack_flag(ack_flag),
    .is_retransmit(is_retransmit), .in_flight(in_flight), .retry_count(retry_count),
    .last_item(last_item)
  );

  localparam int QDepth = tsw_pkg::QueueDepthDefault;

  // predictor copy of configuration and state
  logic [31:0] m_isn;
  logic [31:0] m_rto_init;
  logic [10:0] m_mss;
  bit          m_syn_sent, m_fin_sent, m_timer_on;
  logic [63:0] m_next_seq, m_last_ack, m_max_ack;
  logic [31:0] m_flight, m_send_win, m_peer_win;
  logic [31:0] m_elapsed, m_rto, m_retries;
  logic [63:0] q_end [QDepth];
  logic [10:0] q_len [QDepth];
  logic [1:0]  q_flags [QDepth];
  int          q_head, q_count, seg_count;

  tsw_pkg::res_t expected_words[$];
  int   errors;
  bit   out_gaps;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("tcp_sender_window_retransmit regression: fail");
    $finish;
  end

  function automatic logic [31:0] wrap32(logic [63:0] a);
    return a[31:0] + m_isn;
  endfunction

  // push one expected word using current flight and retry state
  function automatic void expect_word(bit v, logic [31:0] seq, logic [10:0] len,
                                      bit syn, bit fin, bit ack, bit retx, bit last);
    tsw_pkg::res_t r;
    r.segment_valid = v;
    r.seq_number    = seq;
    r.payload_len   = len;
    r.syn_flag      = syn;
    r.fin_flag      = fin;
    r.ack_flag      = ack;
    r.is_retransmit = retx;
    r.in_flight     = m_flight;
    r.retry_count   = m_retries[7:0];
    r.last_item     = last;
    expected_words.push_back(r);
  endfunction

  function automatic bit room_to_send();
    return q_count < QDepth && seg_count < tsw_pkg::MaxSegs;
  endfunction

  function automatic void issue_segment(logic [31:0] len, bit syn, bit fin);
    logic [31:0] seq;
    logic [31:0] l;
    int slot;
    seq = wrap32(m_next_seq);
    l = len + syn + fin;
    slot = (q_head + q_count) % QDepth;
    m_flight += l;
    m_next_seq += l;
    q_end[slot] = m_next_seq;
    q_len[slot] = len[10:0];
    q_flags[slot] = {syn, fin};
    q_count++;
    if (!m_timer_on) begin
      m_elapsed = 0;
      m_rto = m_rto_init;
      m_timer_on = 1;
    end
    seg_count++;
    expect_word(1, seq, len[10:0], syn, fin, 0, 0, 0);
  endfunction

  function automatic void predict_fill(logic [31:0] rem, bit ended);
    logic [31:0] mp, take;
    bit fin;
    mp = (m_mss == 0) ? 32'd1 : {21'd0, m_mss};
    if (!m_syn_sent) begin
      if (room_to_send()) begin
        m_syn_sent = 1;
        issue_segment(0, 1, 0);
      end
      return;
    end
    while (!m_fin_sent && rem > 0 && m_send_win > 0 && room_to_send()) begin
      take = (m_send_win > mp) ? mp : m_send_win;
      fin = 0;
      if (take > rem) take = rem;
      rem -= take;
      m_send_win -= take;
      if (ended && rem == 0 && m_send_win > 0) begin
        fin = 1;
        m_fin_sent = 1;
        m_send_win -= 1;
      end
      issue_segment(take, 0, fin);
    end
    if (!m_fin_sent && ended && rem == 0 && m_send_win > 0 && room_to_send()) begin
      m_send_win -= 1;
      m_fin_sent = 1;
      issue_segment(0, 0, 1);
    end
  endfunction

  // nearest absolute ack to the last one, ties to the larger
  function automatic logic [63:0] unwrap_ackno(logic [31:0] ackno);
    logic [63:0] t, c;
    t = {32'd0, ackno - m_isn} + {m_last_ack[63:32], 32'd0};
    c = m_last_ack;
    if (t > c) begin
      if (t >= 64'h1_0000_0000 && t - c > 64'h8000_0000) t -= 64'h1_0000_0000;
    end else if (c - t >= 64'h8000_0000 && t <= 64'hFFFF_FFFE_FFFF_FFFF) begin
      t += 64'h1_0000_0000;
    end
    return t;
  endfunction

  function automatic void take_ack(logic [31:0] ackno, logic [31:0] win,
                                   logic [31:0] rem, bit ended);
    logic [63:0] a, sum;
    int n;
    int idx;
    a = unwrap_ackno(ackno);
    if (a > m_next_seq) return;
    if (m_next_seq - a > {32'd0, win}) begin
      m_send_win = 0;
      return;
    end
    m_last_ack = a;
    m_peer_win = win;
    n = 0;
    for (int i = 0; i < q_count; i++) begin
      idx = (q_head + i) % QDepth;
      if (q_end[idx] == a) begin
        n = i + 1;
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      m_flight -= q_len[q_head] + q_flags[q_head][1] + q_flags[q_head][0];
      q_head = (q_head + 1) % QDepth;
      q_count--;
    end
    sum = a + win - m_next_seq;
    m_send_win = (win == 0) ? 32'd1 : sum[31:0];
    if (a > m_max_ack) begin
      m_max_ack = a;
      m_rto = m_rto_init;
      m_retries = 0;
      if (q_count > 0) m_elapsed = 0;
    end
    if (q_count == 0) m_timer_on = 0;
    predict_fill(rem, ended);
  endfunction

  function automatic void take_tick(logic [31:0] ms);
    logic [32:0] s;
    logic [63:0] start;
    bit syn, fin;
    if (!m_timer_on) return;
    if (q_count > 0) begin
      s = {1'b0, m_elapsed} + ms;
      m_elapsed = s[32] ? 32'hFFFF_FFFF : s[31:0];
    end else begin
      m_rto = m_rto_init;
      m_elapsed = 0;
    end
    if (m_elapsed >= m_rto) begin
      if (m_peer_win > 0) begin
        if (m_retries < 255) m_retries++;
        m_rto = (m_rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : m_rto * 2;
      end
      m_elapsed = 0;
      if (q_count > 0) begin
        syn = q_flags[q_head][1];
        fin = q_flags[q_head][0];
        start = q_end[q_head] - q_len[q_head] - syn - fin;
        expect_word(1, wrap32(start), q_len[q_head], syn, fin, 0, 1, 0);
      end
    end
  endfunction

  function automatic void predict_event(tsw_pkg::op_t op, logic [31:0] ackno,
                                        logic [15:0] win, logic [15:0] ms,
                                        logic [15:0] rem, bit ended);
    seg_count = 0;
    case (op)
      tsw_pkg::OP_FILL: predict_fill({16'd0, rem}, ended);
      tsw_pkg::OP_ACK:  take_ack(ackno, {16'd0, win}, {16'd0, rem}, ended);
      tsw_pkg::OP_TICK: take_tick({16'd0, ms});
      default: expect_word(1, wrap32(m_next_seq), 0, 0, 0, 1, 0, 0);
    endcase
    expect_word(0, wrap32(m_next_seq), 0, 0, 0, 0, 0, 1);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker
  initial begin
    tsw_pkg::res_t w;
    tsw_pkg::res_t g;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        g = {segment_valid, seq_number, payload_len, syn_flag, fin_flag, ack_flag,
             is_retransmit, in_flight, retry_count, last_item};
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", g.seq_number, 0);
        end else begin
          w = expected_words.pop_front();
          if (g.segment_valid != w.segment_valid)
            report_mismatch("segment_valid", g.segment_valid, w.segment_valid);
          if (g.seq_number != w.seq_number)
            report_mismatch("seq_number", g.seq_number, w.seq_number);
          if (g.payload_len != w.payload_len)
            report_mismatch("payload_len", g.payload_len, w.payload_len);
          if (g.syn_flag != w.syn_flag) report_mismatch("syn_flag", g.syn_flag, w.syn_flag);
          if (g.fin_flag != w.fin_flag) report_mismatch("fin_flag", g.fin_flag, w.fin_flag);
          if (g.ack_flag != w.ack_flag) report_mismatch("ack_flag", g.ack_flag, w.ack_flag);
          if (g.is_retransmit != w.is_retransmit)
            report_mismatch("is_retransmit", g.is_retransmit, w.is_retransmit);
          if (g.in_flight != w.in_flight)
            report_mismatch("in_flight", g.in_flight, w.in_flight);
          if (g.retry_count != w.retry_count)
            report_mismatch("retry_count", g.retry_count, w.retry_count);
          if (g.last_item != w.last_item)
            report_mismatch("last_item", g.last_item, w.last_item);
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      n = out_gaps ? $urandom_range(0, 6) : 0;
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  // send one event word, idling a random gap first when gaps is set; valid stays high into a back-to-back word
  task automatic send_event(tsw_pkg::op_t op, logic [31:0] ackno, logic [15:0] win,
                            logic [15:0] ms, logic [15:0] rem, bit ended, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 6) : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    opcode <= op;
    ack_number <= ackno;
    rcv_window <= win;
    tick_ms <= ms;
    stream_bytes <= rem;
    stream_ended <= ended;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    predict_event(op, ackno, win, ms, rem, ended);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    case (idx)
      tsw_pkg::REG_ISN: m_isn = val;
      tsw_pkg::REG_RTO: m_rto_init = {16'd0, val[15:0]};
      default: m_mss = val[10:0];
    endcase
  endtask

  // ack of everything sent so far, wrapped
  function automatic logic [31:0] full_ack();
    return wrap32(m_next_seq);
  endfunction

  // directed: extremes, every opcode, special cases
  task automatic test_directed();
    send_event(tsw_pkg::OP_TICK, 0, 0, 16'hFFFF, 0, 0, 0);
    send_event(tsw_pkg::OP_EACK, 0, 0, 0, 0, 0, 0);
    send_event(tsw_pkg::OP_FILL, 0, 0, 0, 16'hFFFF, 1, 0);
    send_event(tsw_pkg::OP_ACK, full_ack() + 5, 100, 0, 0, 0, 0);
    send_event(tsw_pkg::OP_ACK, full_ack(), 0, 0, 0, 0, 0);
    send_event(tsw_pkg::OP_FILL, 0, 0, 0, 500, 0, 0);
    send_event(tsw_pkg::OP_TICK, 0, 0, 16'hFFFF, 0, 0, 0);
    send_event(tsw_pkg::OP_ACK, full_ack(), 16'hFFFF, 0, 16'hFFFF, 0, 0);
    send_event(tsw_pkg::OP_ACK, full_ack() - 3, 1, 0, 0, 0, 0);
    send_event(tsw_pkg::OP_ACK, full_ack() - 7, 16'hFFFF, 0, 0, 0, 0);
    send_event(tsw_pkg::OP_TICK, 0, 0, 16'hFFFF, 0, 0, 0);
    send_event(tsw_pkg::OP_TICK, 0, 0, 1, 0, 0, 0);
    send_event(tsw_pkg::OP_ACK, full_ack(), 3000, 0, 2000, 1, 0);
    send_event(tsw_pkg::OP_FILL, 0, 0, 0, 100, 1, 0);
    send_event(tsw_pkg::OP_ACK, full_ack(), 200, 0, 50, 1, 0);
    send_event(tsw_pkg::OP_TICK, 0, 0, 16'hFFFF, 0, 0, 0);
    send_event(tsw_pkg::OP_EACK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
    drain();
  endtask

  // many small segments: queue full and descriptor limit
  task automatic test_queue_limits();
    write_reg(tsw_pkg::REG_MSS, 11'd1);
    send_event(tsw_pkg::OP_ACK, full_ack(), 16'hFFFF, 0, 0, 0, 1);
    send_event(tsw_pkg::OP_FILL, 0, 0, 0, 16'hFFFF, 0, 1);
    send_event(tsw_pkg::OP_FILL, 0, 0, 0, 16'hFFFF, 0, 1);
    send_event(tsw_pkg::OP_TICK, 0, 0, 16'hFFFF, 0, 0, 1);
    send_event(tsw_pkg::OP_ACK, full_ack(), 16'hFFFF, 0, 30, 1, 1);
    drain();
  endtask

  // random events biased to well-formed acks
  task automatic test_random(int count);
    int k;
    tsw_pkg::op_t op;
    logic [31:0] ackno;
    logic [15:0] win, ms, rem;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      ackno = $urandom;
      win = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6000));
      ms = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1500));
      rem = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
      if (k < 20) op = tsw_pkg::OP_FILL;
      else if (k < 65) begin
        op = tsw_pkg::OP_ACK;
        if (k < 45 && q_count > 0)
          ackno = wrap32(q_end[(q_head + $urandom_range(0, q_count - 1)) % QDepth]);
        else if (k < 55) ackno = full_ack() - $urandom_range(0, 3);
      end else if (k < 92) op = tsw_pkg::OP_TICK;
      else op = tsw_pkg::OP_EACK;
      send_event(op, ackno, win, ms, rem, $urandom_range(0, 7) == 0, 1);
      if (i == count / 2) drain();
    end
    drain();
  endtask

  // phase under a new setting on the running connection (no reset)
  task automatic test_setting(logic [31:0] isn, logic [15:0] rto, logic [10:0] mss, int n);
    write_reg(tsw_pkg::REG_ISN, isn);
    write_reg(tsw_pkg::REG_RTO, {16'd0, rto});
    write_reg(tsw_pkg::REG_MSS, {21'd0, mss});
    test_random(n);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; opcode = tsw_pkg::OP_FILL; ack_number = 0; rcv_window = 0;
    tick_ms = 0; stream_bytes = 0; stream_ended = 0;
    errors = 0; out_gaps = 0;
    m_isn = 0; m_rto_init = tsw_pkg::TimeoutDefault; m_mss = tsw_pkg::MaxPayloadDefault;
    m_syn_sent = 0; m_fin_sent = 0; m_timer_on = 0;
    m_next_seq = 0; m_last_ack = 0; m_max_ack = 0;
    m_flight = 0; m_send_win = 0; m_peer_win = 0;
    m_elapsed = 0; m_rto = 0; m_retries = 0;
    q_head = 0; q_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    out_gaps = 1;
    test_queue_limits();
    test_setting(32'hFFFF_FF00, 16'd1, 11'd1100, 120);
    test_setting(32'h7FFF_FFF0, 16'hFFFF, 11'd1460, 120);
    test_setting($urandom, 16'($urandom_range(200, 3000)), 11'($urandom_range(1100, 1460)), 180);
    if (errors == 0) begin
      $display("tcp_sender_window_retransmit regression: pass");
    end else begin
      $display("tcp_sender_window_retransmit regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tsw_pkg.sv
hdl/tsw_front.sv
hdl/tsw_back.sv
hdl/tcp_sender_window_retransmit.sv
bench/tb_top.sv
